>>> hw/rtl/geohash_encoder_defines.svh
// Assertion macros for the geohash encoder RTL.
// No dependencies; included by gh_seq, the module that asserts.
`ifndef GEOHASH_ENCODER_DEFINES_SVH
`define GEOHASH_ENCODER_DEFINES_SVH

// same-cycle implication
`define GH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/gh_pkg.sv
// Types, constants and the base32 alphabet for the geohash encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gh_pkg;

   localparam int GH_MAX_CHARS     = 12;
   localparam int GH_COUNT_W       = 4;
   localparam int GH_CHAR_W        = 7;
   localparam int GH_BITS_PER_CHAR = 5;
   localparam int GH_DIGIT_W       = GH_BITS_PER_CHAR;
   localparam int GH_BIT_CNT_W     = $clog2(GH_BITS_PER_CHAR);

   localparam int GH_LAT_W = 31;
   localparam int GH_LON_W = 32;

   // offsets move the lower bound to zero; spans are the full axis range
   localparam logic [GH_LON_W:0]   GH_LON_OFFSET = 33'd1800000000;
   localparam logic [GH_LON_W-1:0] GH_LON_SPAN   = 32'd3600000000;
   localparam logic [GH_LAT_W:0]   GH_LAT_OFFSET = 32'd900000000;
   localparam logic [GH_LAT_W-1:0] GH_LAT_SPAN   = 31'd1800000000;

   localparam logic [GH_CHAR_W-1:0] GH_ALPHABET [2**GH_DIGIT_W] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
      7'h68, 7'h6A, 7'h6B, 7'h6D, 7'h6E, 7'h70, 7'h71, 7'h72,
      7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A
   };

   typedef struct packed {
      logic signed [GH_LAT_W-1:0] latitude;
      logic signed [GH_LON_W-1:0] longitude;
      logic [GH_COUNT_W-1:0]      char_count;
   } gh_req_type;

   typedef struct packed {
      logic [GH_CHAR_W-1:0]  hash_char;
      logic [GH_COUNT_W-1:0] char_position;
      logic                  last_char;
   } gh_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic lon_turn;
   } gh_ctl_type;

   typedef enum logic {
      GH_IDLE,
      GH_RUN
   } gh_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/geohash_encoder.sv
// Geohash encoder: a coordinate pair in, a stream of base32 geohash characters out.
// Block usage:
//   req channel (req_valid/req_ready/req_data) takes latitude and longitude in
//   signed units of 1e-7 degree and a length in characters (saturated to
//   MAX_CHARS). One transfer per coordinate pair.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) gives one transfer per character,
//   in order, with its position and a last_char flag on the final one. A length
//   of zero gives no transfers.
//   One shared bisection unit computes one hash bit per cycle, alternating
//   longitude and latitude, except while the last bit of a character waits for
//   the result register. Each completed character is looked up in the alphabet
//   and registered in the result register; after the last character of a request
//   the block returns to idle to take the next request.
//   The result register lets the block take the next request while the final
//   character still waits. A stalled receiver holds the result; the block then
//   stops on the last bit of the following character until the register drains.
//   Reset clears the sequencer and drops any pending result; the block is ready
//   in the first cycle after reset is released.
// Depends on gh_pkg, gh_bisect and gh_seq.
`timescale 1ns / 1ps
`default_nettype none

module geohash_encoder #(
   parameter int MAX_CHARS = gh_pkg::GH_MAX_CHARS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire gh_pkg::gh_req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output gh_pkg::gh_rsp_type      rsp_data
);

   gh_pkg::gh_ctl_type ctl;
   logic               hash_bit;

   gh_bisect u_bisect (
      .clock    (clock),
      .ctl      (ctl),
      .req      (req_data),
      .hash_bit (hash_bit)
   );

   gh_seq #(
      .MAX_CHARS (MAX_CHARS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_count (req_data.char_count),
      .ctl       (ctl),
      .hash_bit  (hash_bit),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/gh_bisect.sv
// Bisection step unit: holds both coordinate residuals and yields one hash bit
// per step. Depends on gh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gh_bisect (
   input  wire logic               clock,
   input  wire gh_pkg::gh_ctl_type ctl,
   input  wire gh_pkg::gh_req_type req,
   output logic                    hash_bit
);

   logic [gh_pkg::GH_LON_W-1:0] lon_res_ff, lon_res_in;
   logic [gh_pkg::GH_LAT_W-1:0] lat_res_ff, lat_res_in;
   logic lon_under_ff, lon_under_in, lon_over_ff, lon_over_in;
   logic lat_under_ff, lat_under_in, lat_over_ff, lat_over_in;

   logic [gh_pkg::GH_LON_W:0]   lon_ofs;
   logic [gh_pkg::GH_LAT_W:0]   lat_ofs;
   logic [gh_pkg::GH_LON_W-1:0] res_sel;
   logic [gh_pkg::GH_LON_W-1:0] span_sel;
   logic [gh_pkg::GH_LON_W:0]   twice;
   logic [gh_pkg::GH_LON_W:0]   diff;
   logic [gh_pkg::GH_LON_W-1:0] res_next;
   logic                        ge;

   always_comb begin
      lon_ofs = {req.longitude[gh_pkg::GH_LON_W-1], req.longitude} + gh_pkg::GH_LON_OFFSET;
      lat_ofs = {req.latitude[gh_pkg::GH_LAT_W-1], req.latitude} + gh_pkg::GH_LAT_OFFSET;

      res_sel  = ctl.lon_turn ? lon_res_ff : {1'b0, lat_res_ff};
      span_sel = ctl.lon_turn ? gh_pkg::GH_LON_SPAN : {1'b0, gh_pkg::GH_LAT_SPAN};
      twice    = {res_sel, 1'b0};
      diff     = twice - {1'b0, span_sel};
      ge       = twice >= {1'b0, span_sel};
      res_next = ge ? diff[gh_pkg::GH_LON_W-1:0] : twice[gh_pkg::GH_LON_W-1:0];

      if (ctl.lon_turn) begin
         hash_bit = lon_over_ff | (~lon_under_ff & ge);
      end else begin
         hash_bit = lat_over_ff | (~lat_under_ff & ge);
      end

      lon_res_in   = lon_res_ff;
      lat_res_in   = lat_res_ff;
      lon_under_in = lon_under_ff;
      lon_over_in  = lon_over_ff;
      lat_under_in = lat_under_ff;
      lat_over_in  = lat_over_ff;

      if (ctl.load) begin
         lon_res_in   = lon_ofs[gh_pkg::GH_LON_W-1:0];
         lat_res_in   = lat_ofs[gh_pkg::GH_LAT_W-1:0];
         lon_under_in = lon_ofs[gh_pkg::GH_LON_W];
         lon_over_in  = ~lon_ofs[gh_pkg::GH_LON_W]
                        & (lon_ofs[gh_pkg::GH_LON_W-1:0] >= gh_pkg::GH_LON_SPAN);
         lat_under_in = lat_ofs[gh_pkg::GH_LAT_W];
         lat_over_in  = ~lat_ofs[gh_pkg::GH_LAT_W]
                        & (lat_ofs[gh_pkg::GH_LAT_W-1:0] >= gh_pkg::GH_LAT_SPAN);
      end else if (ctl.step) begin
         if (ctl.lon_turn) begin
            lon_res_in = res_next;
         end else begin
            lat_res_in = res_next[gh_pkg::GH_LAT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      lon_res_ff   <= lon_res_in;
      lat_res_ff   <= lat_res_in;
      lon_under_ff <= lon_under_in;
      lon_over_ff  <= lon_over_in;
      lat_under_ff <= lat_under_in;
      lat_over_ff  <= lat_over_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/gh_seq.sv
// Sequencer: bit and character counters, digit shift register, alphabet
// lookup and result register. Depends on gh_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "geohash_encoder_defines.svh"

module gh_seq #(
   parameter int MAX_CHARS = gh_pkg::GH_MAX_CHARS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [gh_pkg::GH_COUNT_W-1:0]   req_count,
   output gh_pkg::gh_ctl_type                   ctl,
   input  wire logic                            hash_bit,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output gh_pkg::gh_rsp_type                   rsp_data
);

   localparam logic [gh_pkg::GH_COUNT_W-1:0] MaxCount = gh_pkg::GH_COUNT_W'(MAX_CHARS);
   localparam logic [gh_pkg::GH_BIT_CNT_W-1:0] LastBit =
      gh_pkg::GH_BIT_CNT_W'(gh_pkg::GH_BITS_PER_CHAR - 1);

   gh_pkg::gh_state_type state_ff, state_in;
   logic [gh_pkg::GH_COUNT_W-1:0]   count_ff, count_in;
   logic [gh_pkg::GH_COUNT_W-1:0]   pos_ff, pos_in;
   logic [gh_pkg::GH_BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [gh_pkg::GH_DIGIT_W-2:0]   digit_ff, digit_in;
   logic                            lon_turn_ff, lon_turn_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   gh_pkg::gh_rsp_type              rsp_ff, rsp_in;

   logic [gh_pkg::GH_COUNT_W-1:0] count_sat;
   logic                          out_free;
   logic                          char_end;
   logic                          is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gh_pkg::GH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff    <= count_in;
      pos_ff      <= pos_in;
      bit_cnt_ff  <= bit_cnt_in;
      digit_ff    <= digit_in;
      lon_turn_ff <= lon_turn_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      count_sat = (req_count > MaxCount) ? MaxCount : req_count;
      out_free  = ~rsp_valid_ff | rsp_ready;
      char_end  = bit_cnt_ff == LastBit;
      is_last   = (pos_ff + 1'b1) == count_ff;

      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      bit_cnt_in   = bit_cnt_ff;
      digit_in     = digit_ff;
      lon_turn_in  = lon_turn_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      ctl.load     = 1'b0;
      ctl.step     = 1'b0;
      ctl.lon_turn = lon_turn_ff;

      case (state_ff)
         gh_pkg::GH_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load    = 1'b1;
               count_in    = count_sat;
               pos_in      = '0;
               bit_cnt_in  = '0;
               lon_turn_in = 1'b1;
               if (count_sat != '0) begin
                  state_in = gh_pkg::GH_RUN;
               end
            end
         end
         gh_pkg::GH_RUN: begin
            if (~char_end | out_free) begin
               ctl.step    = 1'b1;
               lon_turn_in = ~lon_turn_ff;
               digit_in    = {digit_ff[gh_pkg::GH_DIGIT_W-3:0], hash_bit};
               if (char_end) begin
                  bit_cnt_in           = '0;
                  rsp_valid_in         = 1'b1;
                  rsp_in.hash_char     = gh_pkg::GH_ALPHABET[{digit_ff, hash_bit}];
                  rsp_in.char_position = pos_ff;
                  rsp_in.last_char     = is_last;
                  if (is_last) begin
                     state_in = gh_pkg::GH_IDLE;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end else begin
                  bit_cnt_in = bit_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = gh_pkg::GH_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `GH_ASSERT_NEXT(a_char_to_rsp, clock, reset, ctl.step && char_end, rsp_valid_ff, "completed character not presented")
   `GH_ASSERT_IMPL(a_pos_in_range, clock, reset, state_ff == gh_pkg::GH_RUN, pos_ff < count_ff, "character position beyond count")
   `GH_ASSERT_NEXT(a_last_to_idle, clock, reset, ctl.step && char_end && is_last, state_ff == gh_pkg::GH_IDLE, "last character did not end the item")
   `GH_ASSERT_NEXT(a_axis_toggle, clock, reset, ctl.step, lon_turn_ff != $past(lon_turn_ff), "axis did not alternate after a step")

endmodule

`default_nettype wire

>>> verif/tb.sv
// Testbench for geohash_encoder: coordinate fixes in, geohash characters out, each checked
// against a bit-exact bisection predictor. Requests idle at random; rsp_ready
// stalls in random and periodic phases. Depends on gh_pkg and the geohash_encoder RTL.
`timescale 1ns / 1ps

module tb;

   localparam longint LAT_HALF = 64'sd900000000;
   localparam longint LON_HALF = 64'sd1800000000;
   localparam bit [63:0] ORDER_BIAS = 64'h8000_0000_0000_0000;
   localparam int DRAIN_CYCLES = 80;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   gh_pkg::gh_req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   gh_pkg::gh_rsp_type rsp_data;

   gh_pkg::gh_rsp_type geohash_chars[$];
   string      geohash_digits = "0123456789bcdefghjkmnpqrstuvwxyz";
   int         failures = 0;
   int         burst_left = 0;
   bit [8:0]   rx_cycle = '0;

   geohash_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scale by 2^32 and bias so that signed order becomes unsigned order
   function automatic bit [63:0] to_biased(input longint v);
      bit [63:0] t;
      t = v;
      return (t << 32) + ORDER_BIAS;
   endfunction

   function automatic void predict_geohash(input gh_pkg::gh_req_type fix);
      bit [63:0]  lat_pos, lon_pos, lat_lo, lat_hi, lon_lo, lon_hi, mid;
      bit [4:0]   digit;
      bit [31:0]  kk;
      byte        c;
      int         n;
      bit         lon_turn;
      gh_pkg::gh_rsp_type want;
      lat_pos  = to_biased(longint'($signed(fix.latitude)));
      lon_pos  = to_biased(longint'($signed(fix.longitude)));
      lat_lo   = to_biased(-LAT_HALF);
      lat_hi   = to_biased(LAT_HALF);
      lon_lo   = to_biased(-LON_HALF);
      lon_hi   = to_biased(LON_HALF);
      lon_turn = 1'b1;
      n = fix.char_count;
      if (n > gh_pkg::GH_MAX_CHARS) n = gh_pkg::GH_MAX_CHARS;
      for (int k = 0; k < n; k++) begin
         digit = '0;
         for (int b = 0; b < gh_pkg::GH_BITS_PER_CHAR; b++) begin
            if (lon_turn) begin
               mid = lon_lo + ((lon_hi - lon_lo) >> 1);
               if (lon_pos >= mid) begin
                  digit  = {digit[3:0], 1'b1};
                  lon_lo = mid;
               end else begin
                  digit  = {digit[3:0], 1'b0};
                  lon_hi = mid;
               end
            end else begin
               mid = lat_lo + ((lat_hi - lat_lo) >> 1);
               if (lat_pos >= mid) begin
                  digit  = {digit[3:0], 1'b1};
                  lat_lo = mid;
               end else begin
                  digit  = {digit[3:0], 1'b0};
                  lat_hi = mid;
               end
            end
            lon_turn = !lon_turn;
         end
         c  = geohash_digits[digit];
         kk = k;
         want.hash_char     = c[6:0];
         want.char_position = kk[3:0];
         want.last_char     = (k == n - 1);
         geohash_chars.push_back(want);
      end
   endfunction

   function automatic gh_pkg::gh_req_type make_fix(input longint lat, input longint lon,
                                                   input int count);
      bit [63:0]  lat_bits, lon_bits;
      bit [31:0]  count_bits;
      gh_pkg::gh_req_type fix;
      lat_bits   = lat;
      lon_bits   = lon;
      count_bits = count;
      fix.latitude   = lat_bits[gh_pkg::GH_LAT_W-1:0];
      fix.longitude  = lon_bits[gh_pkg::GH_LON_W-1:0];
      fix.char_count = count_bits[gh_pkg::GH_COUNT_W-1:0];
      return fix;
   endfunction

   // a coordinate on or next to a bisection midpoint of the given axis
   function automatic longint near_midpoint(input longint half);
      int     depth;
      longint slot;
      depth = $urandom_range(1, 12);
      slot  = $urandom_range(0, 1 << depth);
      return -half + ((slot * 2 * half) >>> depth) + $urandom_range(0, 2) - 1;
   endfunction

   function automatic void report_mismatch(input string field, input int want,
                                           input int got);
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      failures++;
   endfunction

   task automatic send_fix(input gh_pkg::gh_req_type fix);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
      req_valid <= 1'b1;
      req_data  <= fix;
      do @(posedge clock); while (!req_ready);
      predict_geohash(fix);
      burst_left--;
   endtask

   task automatic test_lengths();
      int counts[8] = '{0, 1, 5, 11, 12, 13, 14, 15};
      foreach (counts[i])
         send_fix(make_fix(64'sd377749000, -64'sd1224194000, counts[i]));
   endtask

   task automatic test_coordinate_extremes();
      send_fix(make_fix(LAT_HALF, LON_HALF, gh_pkg::GH_MAX_CHARS));
      send_fix(make_fix(-LAT_HALF, -LON_HALF, gh_pkg::GH_MAX_CHARS));
      send_fix(make_fix(0, 0, gh_pkg::GH_MAX_CHARS));
      send_fix(make_fix(-1, -1, gh_pkg::GH_MAX_CHARS));
      send_fix(make_fix(LAT_HALF - 1, LON_HALF - 1, gh_pkg::GH_MAX_CHARS));
      send_fix(make_fix(LAT_HALF, 0, gh_pkg::GH_MAX_CHARS));
      send_fix(make_fix(0, LON_HALF, gh_pkg::GH_MAX_CHARS));
      send_fix(make_fix(64'sd1073741823, 64'sd2147483647, gh_pkg::GH_MAX_CHARS));
      send_fix(make_fix(-64'sd1073741824, -64'sd2147483648, gh_pkg::GH_MAX_CHARS));
   endtask

   task automatic test_random_fixes(input int n);
      longint lat, lon;
      int     count, pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            lat = longint'($urandom_range(0, 1800000000)) - LAT_HALF;
            lon = longint'($urandom_range(0, 32'd3600000000)) - LON_HALF;
         end else if (pick < 9) begin
            lat = near_midpoint(LAT_HALF);
            lon = near_midpoint(LON_HALF);
         end else begin
            lat = $urandom();
            lon = $urandom();
         end
         count = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15)
                                             : $urandom_range(1, gh_pkg::GH_MAX_CHARS);
         send_fix(make_fix(lat, lon, count));
      end
   endtask

   always @(posedge clock) begin : rsp_side
      gh_pkg::gh_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_cycle  <= '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (geohash_chars.size() == 0) begin
               $display("%0t: unexpected transfer, got char %0d position %0d last %0d",
                        $time, rsp_data.hash_char, rsp_data.char_position,
                        rsp_data.last_char);
               failures++;
            end else begin
               want = geohash_chars.pop_front();
               if (rsp_data.hash_char !== want.hash_char)
                  report_mismatch("hash_char", want.hash_char, rsp_data.hash_char);
               if (rsp_data.char_position !== want.char_position)
                  report_mismatch("char_position", want.char_position,
                                  rsp_data.char_position);
               if (rsp_data.last_char !== want.last_char)
                  report_mismatch("last_char", want.last_char, rsp_data.last_char);
            end
         end
         rx_cycle <= rx_cycle + 1'b1;
         case (rx_cycle[8:7])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2'd2: rsp_ready <= (rx_cycle[1:0] == 2'd0);
            default: rsp_ready <= (rx_cycle[4:0] < 5'd6);
         endcase
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_lengths();
      test_coordinate_extremes();
      test_random_fixes(480);
      req_valid <= 1'b0;
      while (geohash_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("geohash_encoder test passed");
      else
         $display("geohash_encoder test failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("geohash_encoder test failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/gh_pkg.sv
hw/rtl/gh_bisect.sv
hw/rtl/gh_seq.sv
hw/rtl/geohash_encoder.sv
verif/tb.sv
